### rtl/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg : shared types and constants of the two-axis point rotator
// Command codes, back-end states and sine polynomial coefficients.
// ----------------------------------------------------------------------------
`default_nettype none
package tpr_pkg;

    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] K1  = 31'd1686629713;
    localparam logic [30:0] K3  = 31'd693598668;
    localparam logic [30:0] K5  = 31'd85569306;
    localparam logic [30:0] K7  = 31'd5026995;
    localparam logic [30:0] K9  = 31'd172274;
    localparam logic [30:0] K11 = 31'd3864;

    typedef enum logic [2:0] {
        CMD_ROTATE   = 3'd0,
        CMD_PITCH_UP = 3'd1,
        CMD_PITCH_DN = 3'd2,
        CMD_YAW_DN   = 3'd3,
        CMD_YAW_UP   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_HORNER,
        ST_LAST,
        ST_PAIR,
        ST_POINT,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // Horner coefficients after the leading K11
    function automatic logic [30:0] horner_coef(input logic [2:0] k);
        logic [30:0] c;
        case (k)
            3'd0: c = K9;
            3'd1: c = K7;
            3'd2: c = K5;
            3'd3: c = K3;
            3'd4: c = K1;
            default: c = K1;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/tpr_queue.sv
// ----------------------------------------------------------------------------
// tpr_queue : two-entry queue between front and back end
// Holds rotate beats with their angle snapshot.
// ----------------------------------------------------------------------------
`default_nettype none
module tpr_queue #(
    parameter int WIDTH = 80
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

### rtl/tpr_front.sv
// ----------------------------------------------------------------------------
// tpr_front : command decode and angle registers
// Applies angle steps at once, queues rotate beats with the current angles.
// ----------------------------------------------------------------------------
`default_nettype none
module tpr_front #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_command,
    input  wire logic [15:0]                  i_angle_step,
    input  wire logic                         i_full,
    output logic                              o_push,
    output logic [ANGLE_BITS-1:0]             o_pitch,
    output logic [ANGLE_BITS-1:0]             o_yaw
);
    import tpr_pkg::*;

    localparam int SW = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;

    logic [ANGLE_BITS-1:0] r_pitch, n_pitch;
    logic [ANGLE_BITS-1:0] r_yaw, n_yaw;
    logic [SW-1:0]         step_ext;
    logic [ANGLE_BITS-1:0] step_a;
    logic                  accept;

    assign step_ext = SW'(i_angle_step);
    assign step_a   = step_ext[ANGLE_BITS-1:0];
    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign o_push   = accept && (i_command == CMD_ROTATE);
    assign o_pitch  = r_pitch;
    assign o_yaw    = r_yaw;

    always_comb begin
        n_pitch = r_pitch;
        n_yaw   = r_yaw;
        if (accept) begin
            case (t_cmd'(i_command))
                CMD_PITCH_UP: n_pitch = r_pitch + step_a;
                CMD_PITCH_DN: n_pitch = r_pitch - step_a;
                CMD_YAW_DN:   n_yaw   = r_yaw - step_a;
                CMD_YAW_UP:   n_yaw   = r_yaw + step_a;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_yaw   <= '0;
        end else begin
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
        end
    end

endmodule
`default_nettype wire

### rtl/tpr_back.sv
// ----------------------------------------------------------------------------
// tpr_back : rotation engine
// Sine/cosine by polynomial, pair products and point products, all on one
// shared multiplier, then truncation and saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module tpr_back #(
    parameter int ANGLE_BITS     = 16,
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_pop,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    input  wire logic signed [COORD_BITS-1:0] i_pz,
    input  wire logic [ANGLE_BITS-1:0]        i_pitch,
    input  wire logic [ANGLE_BITS-1:0]        i_yaw,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [COORD_BITS:0]        o_rx,
    output logic signed [COORD_BITS:0]        o_ry,
    output logic signed [COORD_BITS:0]        o_rz
);
    import tpr_pkg::*;

    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int ACC_W = COORD_BITS + TRIG_FRAC_BITS + 4;
    localparam int SH    = 30 - TRIG_FRAC_BITS;
    localparam int FB    = ANGLE_BITS - 2;
    localparam logic signed [ACC_W-1:0] RND_TZ = ACC_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'd1 << COORD_BITS);
    localparam logic signed [PROD_W-1:0] HALF  = PROD_W'(64'd1 << (TRIG_FRAC_BITS - 1));

    t_state r_state, n_state;
    logic [1:0] r_ang;
    logic [2:0] r_k;
    logic [2:0] r_idx;

    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [ANGLE_BITS-1:0]        r_pitch, r_yaw;
    logic [30:0]                  r_u, r_u2, r_t;
    logic [1:0]                   r_quad;
    logic signed [TW-1:0]         r_trig [4];
    logic signed [TW-1:0]         r_pair [4];
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_pv;
    logic [1:0]                   r_psel;
    logic signed [ACC_W-1:0]      r_acc [3];
    logic                         r_ov;
    logic signed [COORD_BITS:0]   r_rx, r_ry, r_rz;

    logic [ANGLE_BITS-1:0]    ph;
    logic [1:0]               quad_c;
    logic [30:0]              u_c;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [30:0]              mul_sh;
    logic [30:0]              s_clamp;
    logic [32:0]              s_rnd;
    logic signed [TW-1:0]     s_pos, s_val;
    logic signed [PROD_W-1:0] pair_r;
    logic [1:0]               pa, pb;
    logic signed [COORD_BITS-1:0] pt_coord;
    logic signed [TW-1:0]     pt_trig;
    logic                     pt_neg;
    logic [1:0]               pt_acc;
    logic                     out_load;

    function automatic logic signed [COORD_BITS:0] finish_val(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] q;
        q = (acc < 0) ? ((acc + RND_TZ) >>> TRIG_FRAC_BITS) : (acc >>> TRIG_FRAC_BITS);
        if (q > SAT_HI) begin
            q = SAT_HI;
        end
        if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[COORD_BITS:0];
    endfunction

    // phase and quarter-wave argument of the angle in work
    always_comb begin
        ph = r_ang[1] ? r_yaw : r_pitch;
        if (r_ang[0]) begin
            ph = ph + (ANGLE_BITS'(1) << FB);
        end
        quad_c = ph[ANGLE_BITS-1:ANGLE_BITS-2];
        u_c    = 31'(ph[FB-1:0]) << (32 - ANGLE_BITS);
        if (quad_c[0]) begin
            u_c = Q30_ONE - u_c;
        end
    end

    always_comb begin
        case (r_idx[1:0])
            2'd0: begin pa = 2'd0; pb = 2'd3; end
            2'd1: begin pa = 2'd0; pb = 2'd2; end
            2'd2: begin pa = 2'd2; pb = 2'd1; end
            default: begin pa = 2'd1; pb = 2'd3; end
        endcase
    end

    always_comb begin
        pt_coord = r_px;
        pt_trig  = r_trig[3];
        pt_neg   = 1'b0;
        pt_acc   = 2'd0;
        case (r_idx)
            3'd0: begin pt_coord = r_px; pt_trig = r_trig[3]; end
            3'd1: begin pt_coord = r_pz; pt_trig = r_trig[2]; end
            3'd2: begin pt_coord = r_py; pt_trig = r_trig[1]; pt_acc = 2'd1; end
            3'd3: begin
                pt_coord = r_pz; pt_trig = r_pair[0]; pt_neg = 1'b1; pt_acc = 2'd1;
            end
            3'd4: begin pt_coord = r_px; pt_trig = r_pair[1]; pt_acc = 2'd1; end
            3'd5: begin
                pt_coord = r_px; pt_trig = r_pair[2]; pt_neg = 1'b1; pt_acc = 2'd2;
            end
            3'd6: begin pt_coord = r_py; pt_trig = r_trig[0]; pt_acc = 2'd2; end
            3'd7: begin pt_coord = r_pz; pt_trig = r_pair[3]; pt_acc = 2'd2; end
            default: ;
        endcase
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SQUARE: begin
                mul_a = $signed({2'b00, u_c});
                mul_b = $signed({2'b00, u_c});
            end
            ST_HORNER: begin
                mul_a = $signed({2'b00, r_t});
                mul_b = $signed({2'b00, r_u2});
            end
            ST_LAST: begin
                mul_a = $signed({2'b00, r_t});
                mul_b = $signed({2'b00, r_u});
            end
            ST_PAIR: begin
                mul_a = MUL_W'(r_trig[pa]);
                mul_b = MUL_W'(r_trig[pb]);
            end
            ST_POINT: begin
                mul_a = pt_neg ? -MUL_W'(pt_coord) : MUL_W'(pt_coord);
                mul_b = MUL_W'(pt_trig);
            end
            default: ;
        endcase
        mul_p  = mul_a * mul_b;
        mul_sh = mul_p[60:30];
    end

    always_comb begin
        s_clamp = (mul_sh > Q30_ONE) ? Q30_ONE : mul_sh;
        s_rnd   = ({1'b0, s_clamp, 1'b0} + (33'd1 << SH)) >> (SH + 1);
        s_pos   = $signed(TW'(s_rnd[TRIG_FRAC_BITS:0]));
        s_val   = r_quad[1] ? -s_pos : s_pos;
        pair_r  = (mul_p + HALF) >>> TRIG_FRAC_BITS;
    end

    assign o_pop    = (r_state == ST_IDLE) && i_valid;
    assign out_load = (r_state == ST_FINISH) && (!r_ov || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_HORNER;
            ST_HORNER: if (r_k == 3'd4) n_state = ST_LAST;
            ST_LAST:   n_state = (r_ang == 2'd3) ? ST_PAIR : ST_SQUARE;
            ST_PAIR:   if (r_idx == 3'd3) n_state = ST_POINT;
            ST_POINT:  if (r_idx == 3'd7) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc[r_psel] <= r_acc[r_psel] + ACC_W'(r_prod);
        end
        case (r_state)
            ST_IDLE: begin
                r_px    <= i_px;
                r_py    <= i_py;
                r_pz    <= i_pz;
                r_pitch <= i_pitch;
                r_yaw   <= i_yaw;
                r_ang   <= 2'd0;
            end
            ST_SQUARE: begin
                r_u    <= u_c;
                r_quad <= quad_c;
                r_u2   <= mul_sh;
                r_t    <= K11;
                r_k    <= 3'd0;
            end
            ST_HORNER: begin
                r_t <= horner_coef(r_k) - mul_sh;
                r_k <= r_k + 3'd1;
            end
            ST_LAST: begin
                r_trig[r_ang] <= s_val;
                r_ang         <= r_ang + 2'd1;
                r_idx         <= 3'd0;
            end
            ST_PAIR: begin
                r_pair[r_idx[1:0]] <= pair_r[TW-1:0];
                r_idx <= (r_idx == 3'd3) ? 3'd0 : r_idx + 3'd1;
                r_acc[0] <= '0;
                r_acc[1] <= '0;
                r_acc[2] <= '0;
            end
            ST_POINT: begin
                r_prod <= mul_p;
                r_psel <= pt_acc;
                r_idx  <= r_idx + 3'd1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_rx <= finish_val(r_acc[0]);
            r_ry <= finish_val(r_acc[1]);
            r_rz <= finish_val(r_acc[2]);
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == ST_POINT);
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_rx    = r_rx;
    assign o_ry    = r_ry;
    assign o_rz    = r_rz;

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == ST_FINISH)
        else $error("result raised outside finish");

    a_product_from_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_state) == ST_POINT)
        else $error("accumulate without point product");

    a_finish_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FINISH |-> $past(r_state) == ST_DRAIN || $past(r_state) == ST_FINISH)
        else $error("finish entered early");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == ST_SQUARE)
        else $error("pop did not start work");

endmodule
`default_nettype wire

### rtl/two_axis_point_rotator.sv
// ----------------------------------------------------------------------------
// two_axis_point_rotator : rotate points about Y then X by held angles
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_command, i_point_x/y/z
//   result    out        o_valid / i_stall    o_rotated_x/y/z
//   config    in         APB psel/penable     angle_step at byte 0
//
// Angle step commands are applied in the front end. A rotate beat in the back
// end computes four sines on the shared multiplier (seven products each),
// then 4 pair products, 8 point products, drain and finish.
// A two-beat queue lets the front keep taking beats while the back works.
// Synchronous active-low reset clears angles, queue and result valid.
// ----------------------------------------------------------------------------
`default_nettype none
module two_axis_point_rotator #(
    parameter int ANGLE_BITS     = 16,
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 15
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [2:0]                   i_command,
    input  wire logic signed [COORD_BITS-1:0] i_point_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_y,
    input  wire logic signed [COORD_BITS-1:0] i_point_z,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [COORD_BITS:0]        o_rotated_x,
    output logic signed [COORD_BITS:0]        o_rotated_y,
    output logic signed [COORD_BITS:0]        o_rotated_z,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tpr_pkg::*;

    localparam int QW = 3 * COORD_BITS + 2 * ANGLE_BITS;

    logic [15:0]           r_angle_step;
    logic                  q_full, q_push, q_valid, q_pop;
    logic [QW-1:0]         q_in, q_out;
    logic [ANGLE_BITS-1:0] f_pitch, f_yaw;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_angle_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_step <= 16'd182;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_angle_step <= pwdata[15:0];
        end
    end

    tpr_front #(
        .ANGLE_BITS(ANGLE_BITS),
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_angle_step(r_angle_step),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_pitch     (f_pitch),
        .o_yaw       (f_yaw)
    );

    assign q_in = {i_point_x, i_point_y, i_point_z, f_pitch, f_yaw};

    tpr_queue #(.WIDTH(QW)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_out),
        .i_pop  (q_pop)
    );

    tpr_back #(
        .ANGLE_BITS    (ANGLE_BITS),
        .COORD_BITS    (COORD_BITS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_pop  (q_pop),
        .i_px   (q_out[QW-1 -: COORD_BITS]),
        .i_py   (q_out[QW-1-COORD_BITS -: COORD_BITS]),
        .i_pz   (q_out[2*ANGLE_BITS +: COORD_BITS]),
        .i_pitch(q_out[ANGLE_BITS +: ANGLE_BITS]),
        .i_yaw  (q_out[ANGLE_BITS-1:0]),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_rx   (o_rotated_x),
        .o_ry   (o_rotated_y),
        .o_rz   (o_rotated_z)
    );

endmodule
`default_nettype wire

### test/tb_two_axis_point_rotator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_axis_point_rotator : self-checking bench for the point rotator
// Drives angle step and rotate beats with random gaps and result stalls,
// predicts each rotated point in fixed point and compares it field by field.
// The angle step register is reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_two_axis_point_rotator;
    import tpr_pkg::*;

    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 16;
    localparam int FRAC = 15;
    localparam logic [2:0] ADDR_STEP = 3'd0;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
        logic signed [COORD_BITS:0] z;
    } t_point;

    class rotation_scoreboard;
        t_point pending[$];
        logic [15:0] step;
        logic [ANGLE_BITS-1:0] pitch;
        logic [ANGLE_BITS-1:0] yaw;
        int errors;

        function new();
            step = 16'd182;
            pitch = '0;
            yaw = '0;
            errors = 0;
        endfunction

        function longint quarter_sine(longint u);
            longint u2, t;
            u2 = (u * u) >>> 30;
            t = K11;
            t = K9 - ((t * u2) >>> 30);
            t = K7 - ((t * u2) >>> 30);
            t = K5 - ((t * u2) >>> 30);
            t = K3 - ((t * u2) >>> 30);
            t = K1 - ((t * u2) >>> 30);
            t = (t * u) >>> 30;
            if (t > Q30_ONE) t = Q30_ONE;
            return t;
        endfunction

        function longint sine_q15(logic [ANGLE_BITS-1:0] ph);
            longint u, s;
            logic [1:0] quad;
            quad = ph[ANGLE_BITS-1 -: 2];
            u = longint'(ph[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
            if (quad[0]) u = longint'(Q30_ONE) - u;
            s = quarter_sine(u);
            s = (s + (64'sd1 << (30 - FRAC - 1))) >>> (30 - FRAC);
            return quad[1] ? -s : s;
        endfunction

        function longint pair(longint a, longint b);
            return (a * b + (64'sd1 << (FRAC - 1))) >>> FRAC;
        endfunction

        function logic signed [COORD_BITS:0] scale_down(longint acc);
            longint q;
            q = acc / (64'sd1 << FRAC);
            if (q > 65535) q = 65535;
            if (q < -65536) q = -65536;
            return q[COORD_BITS:0];
        endfunction

        function void note_beat(t_cmd cmd, logic signed [15:0] px,
                                logic signed [15:0] py, logic signed [15:0] pz);
            longint sx, cx, sy, cy, ax, ay, az;
            t_point p;
            case (cmd)
                CMD_PITCH_UP: pitch = pitch + step;
                CMD_PITCH_DN: pitch = pitch - step;
                CMD_YAW_DN:   yaw = yaw - step;
                CMD_YAW_UP:   yaw = yaw + step;
                CMD_ROTATE: begin
                    sx = sine_q15(pitch);
                    cx = sine_q15(pitch + (1 << (ANGLE_BITS - 2)));
                    sy = sine_q15(yaw);
                    cy = sine_q15(yaw + (1 << (ANGLE_BITS - 2)));
                    ax = px * cy + pz * sy;
                    ay = py * cx - pz * pair(sx, cy) + px * pair(sx, sy);
                    az = -px * pair(sy, cx) + py * sx + pz * pair(cx, cy);
                    p.x = scale_down(ax);
                    p.y = scale_down(ay);
                    p.z = scale_down(az);
                    pending.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_point got);
            t_point exp_p;
            if (pending.size() == 0) begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            exp_p = pending.pop_front();
            if (got.x !== exp_p.x) begin
                $error("rotated_x: expected %0d, got %0d", exp_p.x, got.x);
                errors++;
            end
            if (got.y !== exp_p.y) begin
                $error("rotated_y: expected %0d, got %0d", exp_p.y, got.y);
                errors++;
            end
            if (got.z !== exp_p.z) begin
                $error("rotated_z: expected %0d, got %0d", exp_p.z, got.z);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_command = '0;
    logic signed [COORD_BITS-1:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [COORD_BITS:0] o_rotated_x, o_rotated_y, o_rotated_z;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rotation_scoreboard sb = new();
    bit calm = 1'b0;
    int idle_cycles = 0;

    always #10 i_clk = ~i_clk;

    two_axis_point_rotator uut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_rotated_x, o_rotated_y, o_rotated_z});
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result-side stalls
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 11);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    task automatic write_step(logic [15:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_STEP; pwdata <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.step = v;
    endtask

    task automatic send_beat(t_cmd cmd, logic signed [15:0] px,
                             logic signed [15:0] py, logic signed [15:0] pz);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_command <= cmd;
        i_point_x <= px; i_point_y <= py; i_point_z <= pz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_beat(cmd, px, py, pz);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_beats(int count);
        logic [2:0] c;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(0, 9) < 5 ? CMD_ROTATE : 3'($urandom_range(1, 7));
            send_beat(t_cmd'(c), 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(CMD_ROTATE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_beat(CMD_ROTATE, -16'sh8000, -16'sh8000, -16'sh8000);
        send_beat(CMD_ROTATE, 16'sh7fff, -16'sh8000, 16'sd0);
        send_beat(CMD_PITCH_UP, 16'sh1234, 16'sd0, 16'sd0);
        send_beat(CMD_YAW_UP, 16'sd0, 16'sd0, 16'sd0);
        send_beat(CMD_ROTATE, -16'sh8000, 16'sh7fff, -16'sh8000);
        send_beat(t_cmd'(3'd5), 16'sd1, 16'sd1, 16'sd1);
        send_beat(t_cmd'(3'd7), 16'sd1, 16'sd1, 16'sd1);
        drain();
        write_step(16'h4000);
        send_beat(CMD_PITCH_UP, 0, 0, 0);
        send_beat(CMD_ROTATE, 16'sd1000, -16'sd2000, 16'sd3000);
        send_beat(CMD_YAW_DN, 0, 0, 0);
        send_beat(CMD_ROTATE, 16'sh7fff, 16'sh7fff, -16'sh8000);
        send_beat(CMD_PITCH_DN, 0, 0, 0);
        send_beat(CMD_PITCH_DN, 0, 0, 0);
        send_beat(CMD_ROTATE, -16'sd1, 16'sd1, -16'sd1);
        send_beat(t_cmd'(3'd6), 0, 0, 0);
        drain();
        write_step(16'hffff);
        send_beat(CMD_YAW_UP, 0, 0, 0);
        send_beat(CMD_ROTATE, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drain();
        write_step(16'h0000);
        random_beats(100);
        drain();
        write_step(16'($urandom));
        random_beats(350);
        drain();
        write_step(16'd182);
        random_beats(350);
        drain();
        write_step(16'($urandom));
        calm = 1'b1;
        random_beats(330);
        drain();

        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
